// ===== rtl/core/saf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// saf_pkg: shared types and constants of the segregated-fit allocator
// Transfer payloads, store controls, status codes, heap geometry and size-class helpers.
// ----------------------------------------------------------------------------
package saf_pkg;

   localparam int PAGE_BYTES  = 4096;
   localparam int HEAP_PAGES  = 256;

   localparam int ADDR_W      = 20;
   localparam int BYTES_W     = 32;
   localparam int STATUS_W    = 3;
   localparam int CLASS_LO    = 4;
   localparam int CLASS_HI    = 11;
   localparam int CLASS_COUNT = CLASS_HI - CLASS_LO + 1;
   localparam int CLASS_W     = $clog2(CLASS_COUNT);
   localparam int GRAN_SHIFT  = CLASS_LO;
   localparam int PAGE_SHIFT  = $clog2(PAGE_BYTES);
   localparam int PAGE_W      = (HEAP_PAGES > 1) ? $clog2(HEAP_PAGES) : 1;
   localparam int PCNT_W      = $clog2(HEAP_PAGES + 1);
   localparam int LINK_W      = ADDR_W - GRAN_SHIFT;
   localparam int SIZE_W      = CLASS_HI + 1;
   localparam int OFF_W       = PAGE_SHIFT + 1;

   localparam logic [BYTES_W-1:0] MAX_BYTES     = BYTES_W'(1 << CLASS_HI);
   localparam logic [SIZE_W-1:0]  GRANULE_BYTES = SIZE_W'(1 << CLASS_LO);

   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   localparam logic [STATUS_W-1:0] ST_ALLOCATED = 3'd0;
   localparam logic [STATUS_W-1:0] ST_ZERO_SIZE = 3'd1;
   localparam logic [STATUS_W-1:0] ST_TOO_LARGE = 3'd2;
   localparam logic [STATUS_W-1:0] ST_HEAP_FULL = 3'd3;
   localparam logic [STATUS_W-1:0] ST_FREED     = 3'd4;
   localparam logic [STATUS_W-1:0] ST_NULL_FREE = 3'd5;
   localparam logic [STATUS_W-1:0] ST_BAD_FREE  = 3'd6;

   typedef struct packed {
      logic                opcode;
      logic [BYTES_W-1:0]  request_bytes;
      logic [ADDR_W-1:0]   block_address;
   } req_type;

   typedef struct packed {
      logic [ADDR_W-1:0]   result_address;
      logic [STATUS_W-1:0] status;
   } rsp_type;

   typedef struct packed {
      logic    valid;
      rsp_type data;
   } done_type;

   typedef struct packed {
      logic               link_we;
      logic [LINK_W-1:0]  link_waddr;
      logic [ADDR_W-1:0]  link_wdata;
      logic [LINK_W-1:0]  link_raddr;
      logic               page_we;
      logic [PAGE_W-1:0]  page_waddr;
      logic [CLASS_W-1:0] page_wdata;
      logic [PAGE_W-1:0]  page_raddr;
   } store_ctl_type;

   // class index for a size of 1 to 2^CLASS_HI bytes
   function automatic logic [CLASS_W-1:0] class_of(input logic [SIZE_W-1:0] size);
      logic [SIZE_W-1:0]  s;
      logic [CLASS_W-1:0] c;
      s = size - SIZE_W'(1);
      c = '0;
      for (int i = CLASS_LO; i < SIZE_W - 1; i++) begin
         if (s[i]) begin
            c = CLASS_W'(i - CLASS_LO + 1);
         end
      end
      return c;
   endfunction

   function automatic logic [SIZE_W-1:0] block_bytes_of(input logic [CLASS_W-1:0] c);
      return GRANULE_BYTES << c;
   endfunction

endpackage

// ===== rtl/core/saf_store.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// saf_store: link and page-class memories
// One write and one registered read port on each of the two memories.
// ----------------------------------------------------------------------------
module saf_store
   import saf_pkg::*;
(
   input  logic               clock,
   input  store_ctl_type      ctl,
   output logic [ADDR_W-1:0]  link_rdata,
   output logic [CLASS_W-1:0] page_rdata
);

   logic [ADDR_W-1:0]  link_mem [1 << LINK_W];
   logic [CLASS_W-1:0] page_mem [1 << PAGE_W];

   always_ff @(posedge clock) begin
      if (ctl.link_we) begin
         link_mem[ctl.link_waddr] <= ctl.link_wdata;
      end
      link_rdata <= link_mem[ctl.link_raddr];
   end

   always_ff @(posedge clock) begin
      if (ctl.page_we) begin
         page_mem[ctl.page_waddr] <= ctl.page_wdata;
      end
      page_rdata <= page_mem[ctl.page_raddr];
   end

endmodule

// ===== rtl/core/saf_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// saf_core: allocator sequencer
// List heads, page counter and an offset adder that chains fresh pages.
// ----------------------------------------------------------------------------
module saf_core
   import saf_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     start,
   input  req_type  req,
   input  logic     take,
   output logic     idle,
   output done_type done
);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_DECODE = 3'd1;
   localparam logic [2:0] S_WALK   = 3'd2;
   localparam logic [2:0] S_RD     = 3'd3;
   localparam logic [2:0] S_POP    = 3'd4;
   localparam logic [2:0] S_FCLS   = 3'd5;
   localparam logic [2:0] S_DONE   = 3'd6;

   logic [2:0]          state_ff, state_in;
   logic                op_ff, op_in;
   logic                zero_ff, zero_in;
   logic                big_ff, big_in;
   logic [CLASS_W-1:0]  cls_ff, cls_in;
   logic [ADDR_W-1:0]   addr_ff, addr_in;
   logic [PCNT_W-1:0]   pages_ff, pages_in;
   logic [PAGE_W-1:0]   page_ff, page_in;
   logic [OFF_W-1:0]    off_ff, off_in;
   logic [ADDR_W-1:0]   heads_ff [CLASS_COUNT];
   logic [ADDR_W-1:0]   heads_in [CLASS_COUNT];
   rsp_type             res_ff, res_in;

   store_ctl_type       ctl;
   logic [ADDR_W-1:0]   link_rdata;
   logic [CLASS_W-1:0]  page_rdata;

   logic [SIZE_W-1:0]   size;
   logic [OFF_W-1:0]    nxt_off;
   logic [ADDR_W-1:0]   cur_addr;
   logic [ADDR_W-1:0]   head;
   logic [PAGE_W-1:0]   free_page;

   saf_store u_store (
      .clock      (clock),
      .ctl        (ctl),
      .link_rdata (link_rdata),
      .page_rdata (page_rdata)
   );

   assign size      = block_bytes_of(cls_ff);
   assign nxt_off   = off_ff + OFF_W'(size);
   assign cur_addr  = ADDR_W'({page_ff, off_ff[PAGE_SHIFT-1:0]});
   assign head      = heads_ff[cls_ff];
   assign free_page = addr_ff[PAGE_SHIFT +: PAGE_W];

   always_comb begin
      state_in = state_ff;
      op_in    = op_ff;
      zero_in  = zero_ff;
      big_in   = big_ff;
      cls_in   = cls_ff;
      addr_in  = addr_ff;
      pages_in = pages_ff;
      page_in  = page_ff;
      off_in   = off_ff;
      heads_in = heads_ff;
      res_in   = res_ff;
      ctl      = '0;
      ctl.link_raddr = head[ADDR_W-1:GRAN_SHIFT];
      ctl.page_raddr = free_page;

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               op_in    = req.opcode;
               zero_in  = (req.request_bytes == '0);
               big_in   = (req.request_bytes > MAX_BYTES);
               cls_in   = class_of(req.request_bytes[SIZE_W-1:0]);
               addr_in  = req.block_address;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            res_in.result_address = '0;
            if (op_ff == OP_ALLOC) begin
               if (zero_ff) begin
                  res_in.status = ST_ZERO_SIZE;
                  state_in      = S_DONE;
               end else if (big_ff) begin
                  res_in.status = ST_TOO_LARGE;
                  state_in      = S_DONE;
               end else if (head != '0) begin
                  state_in = S_POP;
               end else if (pages_ff >= PCNT_W'(HEAP_PAGES)) begin
                  res_in.status = ST_HEAP_FULL;
                  state_in      = S_DONE;
               end else begin
                  ctl.page_we      = 1'b1;
                  ctl.page_waddr   = pages_ff[PAGE_W-1:0];
                  ctl.page_wdata   = cls_ff;
                  pages_in         = pages_ff + PCNT_W'(1);
                  page_in          = pages_ff[PAGE_W-1:0];
                  off_in           = OFF_W'(size);
                  heads_in[cls_ff] = ADDR_W'({pages_ff[PAGE_W-1:0], PAGE_SHIFT'(size)});
                  state_in         = S_WALK;
               end
            end else begin
               if (addr_ff == '0) begin
                  res_in.status = ST_NULL_FREE;
                  state_in      = S_DONE;
               end else if (PCNT_W'(free_page) >= pages_ff) begin
                  res_in.status = ST_BAD_FREE;
                  state_in      = S_DONE;
               end else begin
                  state_in = S_FCLS;
               end
            end
         end
         S_WALK: begin
            ctl.link_we    = 1'b1;
            ctl.link_waddr = cur_addr[ADDR_W-1:GRAN_SHIFT];
            ctl.link_wdata = nxt_off[PAGE_SHIFT] ? '0 :
                             ADDR_W'({page_ff, nxt_off[PAGE_SHIFT-1:0]});
            off_in         = nxt_off;
            if (nxt_off[PAGE_SHIFT]) begin
               state_in = S_RD;
            end
         end
         S_RD: begin
            state_in = S_POP;
         end
         S_POP: begin
            heads_in[cls_ff]      = link_rdata;
            res_in.result_address = head;
            res_in.status         = ST_ALLOCATED;
            state_in              = S_DONE;
         end
         S_FCLS: begin
            ctl.link_we              = 1'b1;
            ctl.link_waddr           = addr_ff[ADDR_W-1:GRAN_SHIFT];
            ctl.link_wdata           = heads_ff[page_rdata];
            heads_in[page_rdata]     = addr_ff;
            res_in.result_address    = '0;
            res_in.status            = ST_FREED;
            state_in                 = S_DONE;
         end
         S_DONE: begin
            if (take) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         pages_ff <= '0;
         heads_ff <= '{default: '0};
      end else begin
         state_ff <= state_in;
         pages_ff <= pages_in;
         heads_ff <= heads_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff   <= op_in;
      zero_ff <= zero_in;
      big_ff  <= big_in;
      cls_ff  <= cls_in;
      addr_ff <= addr_in;
      page_ff <= page_in;
      off_ff  <= off_in;
      res_ff  <= res_in;
   end

   assign idle       = (state_ff == S_IDLE);
   assign done.valid = (state_ff == S_DONE);
   assign done.data  = res_ff;

endmodule

// ===== rtl/core/segregated_fit_allocator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segregated_fit_allocator: power-of-two segregated-fit heap allocator
// Free lists for 16 to 2048 byte classes over a 256-page heap of 4 KiB pages.
// ----------------------------------------------------------------------------
// One request at a time. An allocate served from a non-empty list passes the
// decode, pop and done states, a valid free decode, free-class and done, and a
// rejected request goes from decode to done. A stalled result does not hold the
// core: it returns to idle, takes the next request and keeps that result in
// done until the stalled one transfers. When the class list is empty a fresh
// page is chained first: one link is written per cycle through the single
// write port of the link memory. Memories need no clearing after reset; the
// block is ready as soon as reset is released.
module segregated_fit_allocator
   import saf_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   logic     idle;
   logic     take;
   done_type done;
   logic     rsp_valid_ff, rsp_valid_in;
   rsp_type  rsp_data_ff, rsp_data_in;

   saf_core u_core (
      .clock (clock),
      .reset (reset),
      .start (req_valid & req_ready),
      .req   (req_data),
      .take  (take),
      .idle  (idle),
      .done  (done)
   );

   assign req_ready = idle;
   assign take      = done.valid & (~rsp_valid_ff | rsp_ready);

   always_comb begin
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      rsp_data_in  = rsp_data_ff;
      if (take) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = done.data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== rtl/core/saf_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// saf_checker: port-level checks of the allocator
// Busy after a request transfer, request and result hold, address and status
// agreement.
// ----------------------------------------------------------------------------
module saf_checker
   import saf_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_ready,
   input req_type req_data,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);

   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while busy");

   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |=> req_valid && $stable(req_data))
      else $error("waiting request changed");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

   a_addr_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_data.status == ST_ALLOCATED) ==
                     (rsp_data.result_address != '0)))
      else $error("result address disagrees with status");

endmodule

bind segregated_fit_allocator saf_checker u_saf_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: testbench of the segregated-fit allocator
// Queues allocate and free requests, predicts every response with a shadow
// copy of the free lists, page classes and page counter, and compares each
// response transfer field by field. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb;
   import saf_pkg::*;

   localparam int unsigned RUN_LIMIT = 3000000;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   segregated_fit_allocator dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // shadow allocator state
   logic [ADDR_W-1:0]  free_heads [CLASS_COUNT];
   logic [ADDR_W-1:0]  free_links [1 << LINK_W];
   logic [CLASS_W-1:0] page_class_of [HEAP_PAGES];
   int unsigned        pages_claimed;

   req_type           pending_reqs [$];
   rsp_type           expected_rsps [$];
   logic [ADDR_W-1:0] live_blocks [$];

   rsp_type     predicted_rsp;
   rsp_type     want_rsp;
   int unsigned fail_count = 0;
   int unsigned cycle_count = 0;
   int unsigned req_idle = 0;
   int unsigned rsp_stall = 0;
   int unsigned stall_draw;
   int unsigned item_count = 0;
   bit          calm = 1'b0;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= RUN_LIMIT) begin
         $display("%0t: timeout, %0d responses outstanding", $time, expected_rsps.size());
         $display("== FAIL ==");
         $finish;
      end
   end

   function automatic int unsigned draw_wait();
      return calm ? 0 : $urandom_range(8, 0);
   endfunction

   function automatic rsp_type predict_allocation(input req_type r);
      rsp_type     e;
      int unsigned c, sz, base, cur, nxt, page;
      logic [ADDR_W-1:0] blk;
      e = '0;
      if (r.opcode == OP_ALLOC) begin
         if (r.request_bytes == '0) begin
            e.status = ST_ZERO_SIZE;
         end else if (r.request_bytes > MAX_BYTES) begin
            e.status = ST_TOO_LARGE;
         end else begin
            c = 0;
            while ((32'd16 << c) < r.request_bytes) c++;
            if (free_heads[CLASS_W'(c)] == '0 && pages_claimed >= HEAP_PAGES) begin
               e.status = ST_HEAP_FULL;
            end else begin
               if (free_heads[CLASS_W'(c)] == '0) begin
                  sz = 16 << c;
                  base = pages_claimed * PAGE_BYTES;
                  cur = base + sz;
                  page_class_of[PAGE_W'(pages_claimed)] = CLASS_W'(c);
                  pages_claimed++;
                  free_heads[CLASS_W'(c)] = ADDR_W'(cur);
                  while (cur < base + PAGE_BYTES) begin
                     nxt = cur + sz;
                     free_links[LINK_W'(cur >> GRAN_SHIFT)] =
                        (nxt < base + PAGE_BYTES) ? ADDR_W'(nxt) : '0;
                     cur = nxt;
                  end
               end
               blk = free_heads[CLASS_W'(c)];
               free_heads[CLASS_W'(c)] = free_links[LINK_W'(blk >> GRAN_SHIFT)];
               e.result_address = blk;
               e.status = ST_ALLOCATED;
            end
         end
      end else begin
         if (r.block_address == '0) begin
            e.status = ST_NULL_FREE;
         end else begin
            page = r.block_address >> PAGE_SHIFT;
            if (page >= pages_claimed) begin
               e.status = ST_BAD_FREE;
            end else begin
               c = page_class_of[PAGE_W'(page)];
               free_links[LINK_W'(r.block_address >> GRAN_SHIFT)] = free_heads[CLASS_W'(c)];
               free_heads[CLASS_W'(c)] = r.block_address;
               e.status = ST_FREED;
            end
         end
      end
      return e;
   endfunction

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_idle <= 0;
         for (int i = 0; i < CLASS_COUNT; i++) free_heads[CLASS_W'(i)] = '0;
         pages_claimed = 0;
      end else begin
         if (req_valid && req_ready) begin
            predicted_rsp = predict_allocation(req_data);
            expected_rsps.push_back(predicted_rsp);
            if (predicted_rsp.status == ST_ALLOCATED) begin
               live_blocks.push_back(predicted_rsp.result_address);
            end
         end
         if (!req_valid || req_ready) begin
            if (req_idle != 0) begin
               req_idle <= req_idle - 1;
               req_valid <= 1'b0;
            end else if (pending_reqs.size() != 0) begin
               req_data <= pending_reqs.pop_front();
               req_valid <= 1'b1;
               req_idle <= draw_wait();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // response monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         rsp_stall <= 0;
      end else if (rsp_valid && rsp_ready) begin
         if (expected_rsps.size() == 0) begin
            $display("%0t: unexpected transfer, expected none, actual addr %h status %0d",
                     $time, rsp_data.result_address, rsp_data.status);
            fail_count++;
         end else begin
            want_rsp = expected_rsps.pop_front();
            if (want_rsp.result_address !== rsp_data.result_address) begin
               $display("%0t: result_address mismatch, expected %h, actual %h",
                        $time, want_rsp.result_address, rsp_data.result_address);
               fail_count++;
            end
            if (want_rsp.status !== rsp_data.status) begin
               $display("%0t: status mismatch, expected %0d, actual %0d",
                        $time, want_rsp.status, rsp_data.status);
               fail_count++;
            end
         end
         stall_draw = draw_wait();
         rsp_stall <= stall_draw;
         rsp_ready <= (stall_draw == 0);
      end else if (rsp_stall != 0) begin
         rsp_stall <= rsp_stall - 1;
         rsp_ready <= (rsp_stall == 1);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   task automatic queue_req(input req_type r);
      while (pending_reqs.size() >= 2) @(negedge clock);
      pending_reqs.push_back(r);
   endtask

   task automatic send_alloc(input logic [BYTES_W-1:0] bytes);
      req_type r;
      r.opcode = OP_ALLOC;
      r.request_bytes = bytes;
      r.block_address = ADDR_W'($urandom());
      queue_req(r);
   endtask

   task automatic send_free(input logic [ADDR_W-1:0] addr);
      req_type r;
      r.opcode = OP_FREE;
      r.request_bytes = $urandom();
      r.block_address = addr;
      queue_req(r);
   endtask

   task automatic wait_drained();
      while (pending_reqs.size() != 0 || req_valid || expected_rsps.size() != 0) begin
         @(negedge clock);
      end
   endtask

   task automatic random_item(input int unsigned alloc_pct, input bit big_bias);
      int unsigned roll, cls, lo, hi, idx, page;
      logic [BYTES_W-1:0] bytes;
      logic [ADDR_W-1:0]  blk;
      item_count++;
      if (item_count % 64 == 0) calm = ($urandom_range(3, 0) == 0);
      roll = $urandom_range(99, 0);
      if (roll >= alloc_pct && roll < 92 && live_blocks.size() != 0) begin
         idx = $urandom_range(live_blocks.size() - 1, 0);
         blk = live_blocks[idx];
         live_blocks.delete(idx);
         // keep the granule, scramble the low bits
         if ($urandom_range(3, 0) == 0) blk = blk | ADDR_W'($urandom_range(15, 0));
         send_free(blk);
      end else if (roll < 92) begin
         cls = (big_bias && $urandom_range(1, 0) == 1) ? 7 : $urandom_range(7, 0);
         hi = 16 << cls;
         lo = (cls == 0) ? 1 : (hi >> 1) + 1;
         send_alloc($urandom_range(hi, lo));
      end else begin
         case ($urandom_range(3, 0))
            0: send_alloc('0);
            1: begin
               do bytes = $urandom(); while (bytes <= MAX_BYTES);
               if ($urandom_range(7, 0) == 0) bytes = MAX_BYTES + 1;
               send_alloc(bytes);
            end
            2: send_free('0);
            default: begin
               // stay clear of pages that queued requests may still claim
               if (pages_claimed + 4 < HEAP_PAGES) begin
                  page = $urandom_range(HEAP_PAGES - 1, pages_claimed + 4);
                  blk = ADDR_W'(page * PAGE_BYTES + $urandom_range(PAGE_BYTES - 1, 0));
                  send_free(blk);
               end else begin
                  send_free('0);
               end
            end
         endcase
      end
   endtask

   initial begin : stimulus
      int unsigned       n, cls;
      logic [ADDR_W-1:0] blk;
      @(negedge clock);
      while (reset) @(negedge clock);

      send_alloc('0);
      send_alloc(32'd2049);
      send_alloc(32'hFFFF_FFFF);
      send_free('0);
      send_free(20'hF_FFFF);
      send_alloc(32'd1);
      send_alloc(32'd16);
      send_alloc(32'd17);
      send_alloc(32'd33);
      send_alloc(32'd65);
      send_alloc(32'd129);
      send_alloc(32'd257);
      send_alloc(32'd513);
      send_alloc(32'd1025);
      send_alloc(32'd2048);
      send_free(20'd16);
      send_alloc(32'd9);
      send_free(20'd4096);
      send_alloc(32'd32);
      send_free(20'd8197);
      send_alloc(32'd64);
      send_free(20'd36864);
      send_free(20'd36863);
      send_alloc(32'd2048);
      send_alloc(32'd1536);
      wait_drained();
      live_blocks.delete();

      for (n = 0; n < 900; n++) random_item(55, 1'b0);
      // hold the sender until every response is back
      wait_drained();
      for (n = 0; n < 930; n++) random_item(75, 1'b1);
      wait_drained();

      // double free, then drain that class
      if (live_blocks.size() != 0) begin
         blk = live_blocks[$urandom_range(live_blocks.size() - 1, 0)];
         cls = page_class_of[PAGE_W'(blk >> PAGE_SHIFT)];
         send_free(blk);
         send_free(blk);
         repeat (3) send_alloc(32'd16 << cls);
      end
      wait_drained();
      repeat (20) @(posedge clock);

      if (fail_count == 0 && expected_rsps.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
